// ===== rtl/lphm_pkg.sv =====
// Package for the linear-probing hash map: sizes, request/status codes,
// sequencer states. No dependencies.
package lphm_pkg;

	// number of table slots
	localparam int TABLE_SIZE = 1024;

	localparam int KEY_W      = 31;
	localparam int SLOT_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int SLOT_OUT_W = 10;
	localparam int STAT_W     = 3;
	localparam int MEM_W      = KEY_W + 1;          // {used, key}
	localparam bit IS_POW2    = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_INSERTED = 3'd0,
		STAT_PRESENT  = 3'd1,
		STAT_FOUND    = 3'd2,
		STAT_MISSING  = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HOME,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/lphm_if.sv =====
// Request and response channel interfaces for the hash map.
// Depends on lphm_pkg.
interface lphm_req_if import lphm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [KEY_W-1:0] key;

	modport source (output valid, output req_type, output key, input ready);
	modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface lphm_rsp_if import lphm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [SLOT_OUT_W-1:0] slot;
	logic [STAT_W-1:0]     status;

	modport source (output valid, output slot, output status, input ready);
	modport sink   (input valid, input slot, input status, output ready);
endinterface

// ===== rtl/lphm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lphm_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lphm_home.sv =====
// Home slot unit: key modulo TABLE_SIZE. A mask for a power-of-two table,
// otherwise a reciprocal multiply and back-subtract, each registered. Depends on lphm_pkg.
module lphm_home import lphm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  key,
	output logic              done,
	output logic [SLOT_W-1:0] home
);

	generate
		if (IS_POW2) begin : g_mask
			logic              done_q;
			logic [SLOT_W-1:0] home_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					home_q <= key[SLOT_W-1:0];
				end
			end

			assign done = done_q;
			assign home = home_q;
		end else begin : g_recip
			// floor(key / size) = (key * RECIP) >> RECIP_SH, exact for all 31-bit keys
			localparam int RECIP_SH = KEY_W + SLOT_W;
			localparam int RECIP_W  = KEY_W + 2;
			localparam int PROD_W   = KEY_W + RECIP_W;
			localparam longint unsigned RECIP_M =
				((64'd1 << RECIP_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
			localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_M);
			localparam logic [KEY_W-1:0]   DIVISOR = KEY_W'(TABLE_SIZE);

			logic              step_q;
			logic              done_q;
			logic [KEY_W-1:0]  key_q;
			logic [PROD_W-1:0] prod_q;
			logic [SLOT_W-1:0] home_q;
			logic [KEY_W-1:0]  quot;
			logic [KEY_W-1:0]  back;

			// quotient from the product, then remainder = key - quotient * size
			always_comb begin
				quot = KEY_W'(prod_q >> RECIP_SH);
				back = quot * DIVISOR;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					step_q <= 1'b0;
					done_q <= 1'b0;
				end else begin
					step_q <= start;
					done_q <= step_q;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_q  <= key;
					prod_q <= PROD_W'(key) * PROD_W'(RECIP);
				end
				if (step_q) begin
					home_q <= SLOT_W'(key_q - back);
				end
			end

			assign done = done_q;
			assign home = home_q;
		end
	endgenerate

endmodule

// ===== rtl/linear_probe_hash_map.sv =====
// Linear-probing hash map top level: sequencer, probe compare and slot store.
// Depends on lphm_pkg, lphm_if, lphm_ram, lphm_home.
//
//  port  dir    fields           notes
//  req   sink   req_type, key    insert (0) or look up (1)
//  rsp   source slot, status     one response per request
//
// After reset a clearing pass walks every slot of the store with req.ready low.
// Per request: the home slot (a mask, or a reciprocal multiply and back-subtract for a non-power-of-two table),
// then a store read and a compare per probe (READ, CHECK), a hand-off (DONE) and a return to IDLE
// before the next accept. The READ/CHECK alternation sets the probe rate.
// A pending response waits in the output register while the next request is taken;
// hand-off stalls only while that register is still full.
module linear_probe_hash_map import lphm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lphm_req_if.sink   req,
	lphm_rsp_if.source rsp
);

	state_t                state_q, state_next;
	logic [SLOT_W-1:0]     clr_q;
	logic [SLOT_W-1:0]     pos_q;
	logic [SLOT_W-1:0]     n_q;
	req_type_t             type_q;
	logic [KEY_W-1:0]      key_q;
	logic                  rsp_valid_q;
	logic [SLOT_OUT_W-1:0] res_slot_q;
	status_t               res_stat_q;
	logic [SLOT_OUT_W-1:0] rsp_slot_q;
	status_t               rsp_stat_q;

	logic                  home_start;
	logic                  home_done;
	logic [SLOT_W-1:0]     home;

	logic                  ram_we;
	logic [SLOT_W-1:0]     ram_waddr;
	logic [MEM_W-1:0]      ram_wdata;
	logic [MEM_W-1:0]      ram_rdata;

	logic                  slot_used;
	logic                  key_hit;
	logic                  probe_end;
	logic [SLOT_W-1:0]     pos_next;
	logic [SLOT_OUT_W-1:0] res_slot;
	status_t               res_stat;
	logic                  accept;
	logic                  out_free;

	lphm_home u_home (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (home_start),
		.key    (req.key),
		.done   (home_done),
		.home   (home)
	);

	lphm_ram #(
		.DEPTH (TABLE_SIZE),
		.WIDTH (MEM_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	// probe compare and outcome
	always_comb begin
		slot_used = ram_rdata[KEY_W];
		key_hit   = ram_rdata[KEY_W-1:0] == key_q;
		probe_end = !slot_used || key_hit || (n_q == LAST_SLOT);
		pos_next  = (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;
		if (!slot_used) begin
			if (type_q == REQ_LOOKUP) begin
				res_slot = '0;
				res_stat = STAT_MISSING;
			end else begin
				res_slot = SLOT_OUT_W'(pos_q);
				res_stat = STAT_INSERTED;
			end
		end else if (key_hit) begin
			res_slot = SLOT_OUT_W'(pos_q);
			res_stat = (type_q == REQ_LOOKUP) ? STAT_FOUND : STAT_PRESENT;
		end else begin
			res_slot = '0;
			res_stat = (type_q == REQ_LOOKUP) ? STAT_MISSING : STAT_FULL;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_SLOT) state_next = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) state_next = ST_HOME;
			end
			ST_HOME: begin
				if (home_done) state_next = ST_READ;
			end
			ST_READ: begin
				state_next = ST_CHECK;
			end
			ST_CHECK: begin
				state_next = probe_end ? ST_DONE : ST_READ;
			end
			ST_DONE: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready  = 1'b0;
		home_start = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = pos_q;
		ram_wdata  = {1'b1, key_q};
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				req.ready  = 1'b1;
				home_start = req.valid;
			end
			ST_CHECK: begin
				ram_we = !slot_used && (type_q == REQ_INSERT);
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request, probe and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req_type_t'(req.req_type);
			key_q  <= req.key;
		end
		if (state_q == ST_HOME && home_done) begin
			pos_q <= home;
			n_q   <= '0;
		end else if (state_q == ST_CHECK && !probe_end) begin
			pos_q <= pos_next;
			n_q   <= n_q + 1'b1;
		end
		if (state_q == ST_CHECK && probe_end) begin
			res_slot_q <= res_slot;
			res_stat_q <= res_stat;
		end
		// result moves to the output register once it is free
		if (state_q == ST_DONE && out_free) begin
			rsp_slot_q <= res_slot_q;
			rsp_stat_q <= res_stat_q;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.slot   = rsp_slot_q;
	assign rsp.status = rsp_stat_q;

	// no request taken while the store is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !req.ready)
		else $error("request accepted during clearing pass");

	// store written only by the clearing pass or a claiming insert
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR ||
			(state_q == ST_CHECK && type_q == REQ_INSERT)))
		else $error("unexpected store write");

	// an accepted request always starts with the home slot computation
	a_accept_to_home: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_HOME)
		else $error("accept did not enter home stage");

	// misses and full-table responses report slot zero
	a_miss_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == STAT_MISSING || rsp.status == STAT_FULL)
		|-> rsp.slot == '0)
		else $error("miss response with nonzero slot");

endmodule
